FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL; both sample on clk_i and
// stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression is never true.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: src/pch_pkg.sv
package pch_pkg;

  // Sizes of the histogram
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned NumBins       = 95;
  localparam int unsigned BinW          = 7;
  localparam logic [7:0]  FirstPrint    = 8'd32;
  localparam logic [7:0]  LastPrint     = 8'd126;

  // Request codes
  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqData  = 2'd1;
  localparam logic [1:0] ReqClose = 2'd2;
  localparam logic [1:0] ReqRead  = 2'd3;

  // Result kinds
  localparam logic [1:0] KindCount = 2'd0;
  localparam logic [1:0] KindFail  = 2'd1;
  localparam logic [1:0] KindBin   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [31:0] expected_length;
    logic [6:0]  bin_index;
  } pch_req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] result_value;
    logic [6:0]  result_bin;
  } pch_res_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic accept;
    logic byte_upd;
    logic commit_rd;
    logic commit_wr;
    logic bin_rsp;
  } pch_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       sess_open;
    logic       last_byte;
    logic       last_idx;
  } pch_stat_t;

  typedef enum logic [2:0] {
    StIdle,
    StByteUpd,
    StCommitRd,
    StCommitWr,
    StBinRsp
  } pch_state_e;

endpackage

FILE: src/pch_ctrl.sv
module pch_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pch_pkg::pch_stat_t  stat_i,
  output pch_pkg::pch_cmd_t   cmd_o,
  output logic                busy_o
);
  import pch_pkg::*;

  pch_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          if (stat_i.req_type == ReqData && stat_i.sess_open) begin
            state_d = StByteUpd;
          end else if (stat_i.req_type == ReqRead) begin
            state_d = StBinRsp;
          end
        end
      end
      StByteUpd:  state_d = stat_i.last_byte ? StCommitRd : StIdle;
      StCommitRd: state_d = StCommitWr;
      StCommitWr: state_d = stat_i.last_idx ? StIdle : StCommitRd;
      StBinRsp:   state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      StByteUpd:  cmd_o.byte_upd  = 1'b1;
      StCommitRd: cmd_o.commit_rd = 1'b1;
      StCommitWr: cmd_o.commit_wr = 1'b1;
      StBinRsp:   cmd_o.bin_rsp   = 1'b1;
      default:    busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/pch_dp.sv
module pch_dp #(
  parameter int unsigned CountWidth = pch_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pch_pkg::pch_req_t  req_i,
  input  pch_pkg::pch_cmd_t  cmd_i,
  output pch_pkg::pch_stat_t stat_o,
  output logic               done_o,
  output pch_pkg::pch_res_t  res_o
);
  import pch_pkg::*;

  // Bin memories; an entry whose valid bit is clear reads as zero
  logic [CountWidth-1:0] sess_mem [NumBins];
  logic [CountWidth-1:0] tot_mem  [NumBins];
  logic [CountWidth-1:0] sess_rd_q, tot_rd_q;
  logic [NumBins-1:0]    sess_vld_q, tot_vld_q;

  logic [31:0]           remain_q;
  logic [CountWidth-1:0] prnt_q;
  logic                  open_q;
  logic [BinW-1:0]       idx_q;
  logic [7:0]            byte_q;
  logic [BinW-1:0]       bin_q;
  logic                  done_q;
  pch_res_t              res_q, res_d;
  logic                  emit_d;

  logic                  in_prnt, byte_prnt, bin_ok;
  logic [BinW-1:0]       in_addr, rd_bin_addr, byte_addr, bin_safe;
  logic [BinW-1:0]       sess_raddr, tot_raddr, upd_addr;
  logic [CountWidth-1:0] sess_cur, tot_cur;

  // Address decode
  always_comb begin
    in_prnt     = req_i.data_byte inside {[FirstPrint:LastPrint]};
    in_addr     = in_prnt ? BinW'(req_i.data_byte - FirstPrint) : '0;
    rd_bin_addr = (req_i.bin_index < BinW'(NumBins)) ? req_i.bin_index : '0;
    byte_prnt   = byte_q inside {[FirstPrint:LastPrint]};
    byte_addr   = byte_prnt ? BinW'(byte_q - FirstPrint) : '0;
    bin_ok      = bin_q < BinW'(NumBins);
    bin_safe    = bin_ok ? bin_q : '0;
    sess_raddr  = cmd_i.commit_rd ? idx_q : in_addr;
    tot_raddr   = cmd_i.commit_rd ? idx_q : rd_bin_addr;
    upd_addr    = cmd_i.commit_wr ? idx_q : byte_addr;
    sess_cur    = sess_vld_q[upd_addr] ? sess_rd_q : '0;
    tot_cur     = tot_vld_q[idx_q] ? tot_rd_q : '0;
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept || cmd_i.commit_rd) begin
      sess_rd_q <= sess_mem[sess_raddr];
      tot_rd_q  <= tot_mem[tot_raddr];
    end
    if (cmd_i.byte_upd && byte_prnt) begin
      sess_mem[byte_addr] <= sess_cur + CountWidth'(1);
    end
    if (cmd_i.commit_wr) begin
      tot_mem[idx_q] <= tot_cur + sess_cur;
    end
  end

  // Result select
  always_comb begin
    emit_d = 1'b0;
    res_d  = '0;
    if (cmd_i.accept) begin
      if (req_i.req_type == ReqStart && req_i.expected_length == '0) begin
        emit_d            = 1'b1;
        res_d.result_kind = KindCount;
      end else if (req_i.req_type == ReqClose && open_q) begin
        emit_d            = 1'b1;
        res_d.result_kind = KindFail;
      end
    end else if (cmd_i.commit_wr && stat_o.last_idx) begin
      emit_d             = 1'b1;
      res_d.result_kind  = KindCount;
      res_d.result_value = 32'(prnt_q);
    end else if (cmd_i.bin_rsp) begin
      emit_d             = 1'b1;
      res_d.result_kind  = KindBin;
      res_d.result_value = (bin_ok && tot_vld_q[bin_safe]) ? 32'(tot_rd_q) : '0;
      res_d.result_bin   = bin_q;
    end
  end

  // Hold the request payload and register the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= req_i.data_byte;
      bin_q  <= req_i.bin_index;
    end
    if (emit_d) begin
      res_q <= res_d;
    end
  end

  // Session and sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_vld_q <= '0;
      tot_vld_q  <= '0;
      remain_q   <= '0;
      prnt_q     <= '0;
      open_q     <= 1'b0;
      idx_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= emit_d;
      if (cmd_i.accept) begin
        case (req_i.req_type)
          ReqStart: begin
            sess_vld_q <= '0;
            prnt_q     <= '0;
            remain_q   <= req_i.expected_length;
            open_q     <= req_i.expected_length != '0;
          end
          ReqClose: begin
            if (open_q) begin
              sess_vld_q <= '0;
              prnt_q     <= '0;
              remain_q   <= '0;
              open_q     <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.byte_upd) begin
        if (byte_prnt) begin
          sess_vld_q[byte_addr] <= 1'b1;
          prnt_q                <= prnt_q + CountWidth'(1);
        end
        remain_q <= remain_q - 32'd1;
      end
      if (cmd_i.commit_wr) begin
        tot_vld_q[idx_q] <= 1'b1;
        if (stat_o.last_idx) begin
          idx_q      <= '0;
          sess_vld_q <= '0;
          prnt_q     <= '0;
          remain_q   <= '0;
          open_q     <= 1'b0;
        end else begin
          idx_q <= idx_q + BinW'(1);
        end
      end
    end
  end

  assign stat_o.req_type  = req_i.req_type;
  assign stat_o.sess_open = open_q;
  assign stat_o.last_byte = remain_q == 32'd1;
  assign stat_o.last_idx  = idx_q == BinW'(NumBins - 1);

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: src/printable_char_histogram.sv
// Start, close and stray bytes finish at acceptance; a result, if any, shows in the cycle after.
// A data byte reads its bin, then increments it; a read request answers via StBinRsp.
// The last byte of a session adds a commit sweep: a read and a write step for each of 95 bins.
// Throughput: one request per cycle while busy_o is low; the result strobe is never stalled.
// Reset: asynchronous, active low; clears all bin valid bits at once, no clearing pass.
`include "assert_macros.svh"

module printable_char_histogram #(
  parameter int unsigned COUNT_WIDTH = pch_pkg::CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pch_pkg::pch_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output pch_pkg::pch_res_t res_o
);
  import pch_pkg::*;

  pch_cmd_t   cmd;
  pch_stat_t  stat;
  logic [4:0] cmd_vec;

  pch_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  pch_dp #(
    .CountWidth(COUNT_WIDTH)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .done_o(done_o),
    .res_o (res_o)
  );

  assign cmd_vec = cmd;

  `ASSERT_CLK(a_cmd_excl, $onehot0(cmd_vec), "controller issued two commands at once")
  `ASSERT_CLK(a_commit_order, cmd.commit_wr |-> $past(cmd.commit_rd), "commit write without read")
  `ASSERT_NEVER(a_fail_zero, done_o && res_o.result_kind == KindFail && res_o.result_value != '0, "failure result carries a value")
  `ASSERT_CLK(a_read_answer, start_i && !busy_o && req_i.req_type == ReqRead |-> ##2 (done_o && res_o.result_kind == KindBin), "bin read not answered")

endmodule

FILE: tb/printable_char_histogram_test.sv
`timescale 1ns / 100ps

module printable_char_histogram_test;
  import pch_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomItems = 1750;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DrainCycles = 400;

  // One directed request, optionally with its result typed in by hand
  typedef struct {
    pch_req_t req;
    bit       pinned;
    bit       has_res;
    pch_res_t res;
  } dir_row_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  pch_req_t req_i   = '0;
  logic     busy_o;
  logic     done_o;
  pch_res_t res_o;

  // Hand-typed expectation travels with the request it belongs to
  logic     pin_on  = 1'b0;
  logic     pin_has = 1'b0;
  pch_res_t pin_res = '0;

  // Histogram mirror
  logic [31:0] sess_bins [NumBins];
  logic [31:0] total_bins [NumBins];
  logic [31:0] bytes_left;
  logic [31:0] sess_printable;
  logic        sess_open;

  pch_res_t    pending_results [$];
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  bit          gap_on       = 1'b1;

  printable_char_histogram dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #1 clk_i = ~clk_i;

  // Drop the open session and its bins
  task automatic clear_session();
    for (int i = 0; i < NumBins; i++) sess_bins[i] = '0;
    bytes_left     = '0;
    sess_printable = '0;
    sess_open      = 1'b0;
  endtask

  // Advance the histogram mirror by one request
  task automatic histogram_step(input pch_req_t r, output logic has, output pch_res_t res);
    int unsigned k;
    has = 1'b0;
    res = '0;
    case (r.req_type)
      ReqStart: begin
        clear_session();
        if (r.expected_length == '0) begin
          has = 1'b1;
          res.result_kind = KindCount;
        end else begin
          sess_open  = 1'b1;
          bytes_left = r.expected_length;
        end
      end
      ReqData: begin
        if (sess_open) begin
          if (r.data_byte >= FirstPrint && r.data_byte <= LastPrint) begin
            k = r.data_byte - FirstPrint;
            sess_bins[k]   = sess_bins[k] + 32'd1;
            sess_printable = sess_printable + 32'd1;
          end
          bytes_left = bytes_left - 32'd1;
          if (bytes_left == '0) begin
            for (int i = 0; i < NumBins; i++) total_bins[i] = total_bins[i] + sess_bins[i];
            has = 1'b1;
            res.result_kind  = KindCount;
            res.result_value = sess_printable;
            clear_session();
          end
        end
      end
      ReqClose: begin
        if (sess_open) begin
          clear_session();
          has = 1'b1;
          res.result_kind = KindFail;
        end
      end
      default: begin
        has = 1'b1;
        res.result_kind  = KindBin;
        res.result_bin   = r.bin_index;
        res.result_value = (r.bin_index < NumBins) ? total_bins[r.bin_index] : '0;
      end
    endcase
  endtask

  function automatic void flag_error(string msg);
    if (mismatches < MaxReports) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  // Predict on each accepted request, check each result strobe
  always @(posedge clk_i) begin : monitor
    logic     has;
    pch_res_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        histogram_step(req_i, has, want);
        if (pin_on) begin
          has  = pin_has;
          want = pin_res;
        end
        if (has) pending_results.push_back(want);
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result kind=%0d value=%0d bin=%0d",
                               res_o.result_kind, res_o.result_value, res_o.result_bin));
        end else begin
          want = pending_results.pop_front();
          if (res_o.result_kind !== want.result_kind || res_o.result_value !== want.result_value ||
              res_o.result_bin !== want.result_bin) begin
            flag_error($sformatf("expected kind=%0d value=%0d bin=%0d, got kind=%0d value=%0d bin=%0d",
                                 want.result_kind, want.result_value, want.result_bin,
                                 res_o.result_kind, res_o.result_value, res_o.result_bin));
          end
        end
      end
      stall_cycles <= ((start_i && !busy_o) || done_o) ? 0 : stall_cycles + 1;
    end
  end

  // End the run if the block stops moving
  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // Hold the request until the block takes it, with a random gap ahead of it
  task automatic issue(input pch_req_t r, input bit pinned = 1'b0, input bit has = 1'b0,
                       input pch_res_t res = '0);
    if (gap_on && $urandom_range(99) < 20) begin
      start_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    pin_on  <= pinned;
    pin_has <= has;
    pin_res <= res;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic pch_req_t mk_req(logic [1:0] t, logic [7:0] b, logic [31:0] len,
                                      logic [6:0] bin);
    pch_req_t r;
    r.req_type        = t;
    r.data_byte       = b;
    r.expected_length = len;
    r.bin_index       = bin;
    return r;
  endfunction

  // Request of the given type with every other field random
  function automatic pch_req_t rand_req(logic [1:0] t);
    return mk_req(t, 8'($urandom_range(255, 0)), $urandom, 7'($urandom_range(127, 0)));
  endfunction

  function automatic pch_res_t mk_res(logic [1:0] k, logic [31:0] v, logic [6:0] bin);
    pch_res_t res;
    res.result_kind  = k;
    res.result_value = v;
    res.result_bin   = bin;
    return res;
  endfunction

  function automatic dir_row_t mk_row(pch_req_t r, bit pinned = 1'b0, bit has = 1'b0,
                                      pch_res_t res = '0);
    dir_row_t row;
    row.req     = r;
    row.pinned  = pinned;
    row.has_res = has;
    row.res     = res;
    return row;
  endfunction

  function automatic pch_req_t read_req();
    pch_req_t r;
    r = rand_req(ReqRead);
    r.bin_index = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 95))
                                           : 7'($urandom_range(94, 0));
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(99) < 75) ? 8'($urandom_range(126, 32)) : 8'($urandom_range(255, 0));
  endfunction

  initial begin : stimulus
    dir_row_t    dir_rows [$];
    pch_req_t    r;
    int unsigned n_items;
    int unsigned len;
    int unsigned cut;
    int unsigned sel;
    n_items = 0;
    for (int i = 0; i < NumBins; i++) total_bins[i] = '0;
    clear_session();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty bins, stray requests, restarts and early closes
    dir_rows.push_back(mk_row(mk_req(ReqRead, 8'd0, 32'd0, 7'd0), 1, 1, mk_res(KindBin, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(ReqRead, 8'd0, 32'd0, 7'd94), 1, 1, mk_res(KindBin, 0, 94)));
    dir_rows.push_back(mk_row(mk_req(ReqRead, 8'd0, 32'd0, 7'd127), 1, 1,
                              mk_res(KindBin, 0, 127)));
    dir_rows.push_back(mk_row(mk_req(ReqData, "A", 32'd0, 7'd0), 1, 0));
    dir_rows.push_back(mk_row(mk_req(ReqClose, 8'd0, 32'd0, 7'd0), 1, 0));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'd0, 7'd0), 1, 1,
                              mk_res(KindCount, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'd3, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, 8'd32, 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, 8'd126, 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, 8'd0, 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqRead, 8'd0, 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqRead, 8'd0, 32'd0, 7'd94)));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'd5, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, 8'hFF, 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqClose, 8'd0, 32'd0, 7'd0), 1, 1, mk_res(KindFail, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'd4, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, "x", 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'd2, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, 8'h7F, 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, "z", 32'd0, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'd7, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'd0, 7'd0), 1, 1,
                              mk_res(KindCount, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(ReqData, "q", 32'd0, 7'd0), 1, 0));
    dir_rows.push_back(mk_row(mk_req(ReqStart, 8'd0, 32'hFFFF_FFFF, 7'd0)));
    dir_rows.push_back(mk_row(mk_req(ReqClose, 8'd0, 32'd0, 7'd0), 1, 1, mk_res(KindFail, 0, 0)));
    dir_rows.push_back(mk_row(mk_req(ReqRead, 8'd0, 32'd0, 7'd90)));
    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].has_res,
                                dir_rows[i].res);

    // Random: mostly complete sessions, some cut short, reads and stray traffic
    while (n_items < RandomItems) begin
      gap_on = (n_items < 700 || n_items > 1000);
      sel = $urandom_range(99);
      if (sel < 70) begin
        sel = $urandom_range(99);
        len = (sel < 5)  ? 0 :
              (sel < 15) ? 1 :
              (sel < 97) ? $urandom_range(16, 2) : $urandom_range(300, 100);
        cut = ($urandom_range(99) < 85) ? len : $urandom_range(len, 0);
        r = rand_req(ReqStart);
        r.expected_length = len;
        issue(r);
        n_items++;
        for (int i = 0; i < cut; i++) begin
          if ($urandom_range(99) < 4) begin
            issue(read_req());
            n_items++;
          end
          r = rand_req(ReqData);
          r.data_byte = rand_byte();
          issue(r);
          n_items++;
        end
        if (cut < len && $urandom_range(1) == 1) begin
          issue(rand_req(ReqClose));
          n_items++;
        end
      end else if (sel < 82) begin
        issue(read_req());
        n_items++;
      end else if (sel < 90) begin
        // open with a wild length, feed a few bytes, hang up
        issue(rand_req(ReqStart));
        n_items++;
        repeat ($urandom_range(3, 0)) begin
          r = rand_req(ReqData);
          r.data_byte = rand_byte();
          issue(r);
          n_items++;
        end
        issue(rand_req(ReqClose));
        n_items++;
      end else begin
        issue(rand_req(($urandom_range(1) == 1) ? ReqData : ReqClose));
      end
    end

    // Drain
    start_i <= 1'b0;
    pin_on  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: printable_char_histogram.f
+incdir+src
src/pch_pkg.sv
src/pch_ctrl.sv
src/pch_dp.sv
src/printable_char_histogram.sv
tb/printable_char_histogram_test.sv
